FILE: src/cbm_pkg.sv
package cbm_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_CHAIN_MODE  = 3'd0;
    localparam logic [2:0] REG_DECRYPT_DIR = 3'd1;
    localparam logic [2:0] REG_KEY_LOW     = 3'd2;
    localparam logic [2:0] REG_KEY_HIGH    = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH  = 3'd4;
    localparam logic [2:0] REG_IV_LOW      = 3'd5;
    localparam logic [2:0] REG_IV_HIGH     = 3'd6;

    // Chaining mode codes; the unused code behaves as ECB.
    localparam logic [1:0] MODE_ECB  = 2'd0;
    localparam logic [1:0] MODE_CBC  = 2'd1;
    localparam logic [1:0] MODE_PCBC = 2'd2;

    localparam int MAX_KEY_BYTES = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       length_error;
    } t_out_item;

    // Configuration register contents as seen by the datapath.
    typedef struct packed {
        logic [1:0]  chain_mode;
        logic        decrypt_dir;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [4:0]  key_length;
        logic [63:0] iv_low;
        logic [63:0] iv_high;
    } t_cfg;

    // Per-item control from the position sequencer.
    typedef struct packed {
        logic [7:0] key_byte;
        logic [7:0] iv_byte;
        logic       first;
        logic       block_end;
    } t_seq;

    // Byte idx of a 16-byte value split over two 64-bit words.
    function automatic logic [7:0] pick_byte(input logic [63:0] lo,
                                             input logic [63:0] hi,
                                             input logic [3:0]  idx);
        logic [127:0] w;
        w = {hi, lo};
        return w[{idx, 3'b000} +: 8];
    endfunction

    // Key length actually in use: zero acts as one, above 16 acts as 16.
    function automatic logic [4:0] used_key_length(input logic [4:0] len);
        logic [4:0] r;
        if (len == 5'd0) begin
            r = 5'd1;
        end else if (len > 5'(MAX_KEY_BYTES)) begin
            r = 5'(MAX_KEY_BYTES);
        end else begin
            r = len;
        end
        return r;
    endfunction

endpackage

FILE: src/cbm_cfg_regs.sv
module cbm_cfg_regs
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output t_cfg        o_cfg
);

    // Reset contents: everything zero except the key length, which starts at 16.
    localparam t_cfg CFG_RESET = '{
        chain_mode:  MODE_ECB,
        decrypt_dir: 1'b0,
        key_low:     64'd0,
        key_high:    64'd0,
        key_length:  5'(MAX_KEY_BYTES),
        iv_low:      64'd0,
        iv_high:     64'd0
    };

    t_cfg r_cfg;

    // Register file; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CHAIN_MODE:  r_cfg.chain_mode  <= i_cfg_data[1:0];
                REG_DECRYPT_DIR: r_cfg.decrypt_dir <= i_cfg_data[0];
                REG_KEY_LOW:     r_cfg.key_low     <= i_cfg_data;
                REG_KEY_HIGH:    r_cfg.key_high    <= i_cfg_data;
                REG_KEY_LENGTH:  r_cfg.key_length  <= i_cfg_data[4:0];
                REG_IV_LOW:      r_cfg.iv_low      <= i_cfg_data;
                REG_IV_HIGH:     r_cfg.iv_high     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/cbm_chain_ram.sv
module cbm_chain_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/cbm_seq.sv
module cbm_seq
    import cbm_pkg::*;
#(
    parameter int BLOCK_BYTES = 16,
    parameter int AW          = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_adv,
    input  logic          i_eom,
    output logic [AW-1:0] o_pos,
    output t_seq          o_seq
);

    logic [AW-1:0] r_pos, n_pos;
    logic [3:0]    r_kidx, n_kidx;
    logic          r_first, n_first;

    logic [4:0] klen;
    logic [3:0] kidx_eff;
    logic       block_end;

    // Current key index, wrapped when it has run past the length in use.
    always_comb begin
        klen      = used_key_length(i_cfg.key_length);
        kidx_eff  = ({1'b0, r_kidx} >= klen) ? 4'd0 : r_kidx;
        block_end = (r_pos == AW'(BLOCK_BYTES - 1));
    end

    // Position, key index and first-block flag for the next item.
    always_comb begin
        n_pos   = r_pos;
        n_kidx  = r_kidx;
        n_first = r_first;
        if (i_adv) begin
            if (i_eom) begin
                n_pos   = '0;
                n_kidx  = 4'd0;
                n_first = 1'b1;
            end else if (block_end) begin
                n_pos   = '0;
                n_kidx  = 4'd0;
                n_first = 1'b0;
            end else begin
                n_pos  = r_pos + 1'b1;
                n_kidx = (({1'b0, kidx_eff} + 5'd1) >= klen) ? 4'd0 : (kidx_eff + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_kidx  <= 4'd0;
            r_first <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_kidx  <= n_kidx;
            r_first <= n_first;
        end
    end

    assign o_pos           = r_pos;
    assign o_seq.key_byte  = pick_byte(i_cfg.key_low, i_cfg.key_high, kidx_eff);
    assign o_seq.iv_byte   = pick_byte(i_cfg.iv_low, i_cfg.iv_high, 4'(r_pos));
    assign o_seq.first     = r_first;
    assign o_seq.block_end = block_end;

endmodule

FILE: src/xor_block_cipher_modes.sv
// Pipeline: an accepted input item is held in stage one, then in the output register.
// Throughput: one item per cycle unless the output stalls; the chain store is
// read on intake and written back as the item leaves stage one, with same-entry forwarding.
// Reset: synchronous, active low; resets the valid flags, configuration registers,
// position, key index and first-block flag. The chain store is not cleared: it is
// only used after the first block of a message has written it.
module xor_block_cipher_modes
    import cbm_pkg::*;
#(
    parameter int BLOCK_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eom;
        logic       err;
        logic [7:0] key_byte;
        logic [7:0] iv_byte;
        logic       first;
    } t_s1;

    t_cfg          cfg;
    t_seq          seq;
    logic [AW-1:0] pos;

    logic          in_acc;
    logic          adv;
    logic          r_s1_vld;
    t_s1           r_s1;
    logic [AW-1:0] r_s1_pos;
    logic          r_out_vld;
    t_out_item     r_out;

    logic [7:0] rd_data;
    logic [7:0] fb;
    logic [7:0] res;
    logic [7:0] new_fb;

    cbm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cbm_seq #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .AW          (AW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (in_acc),
        .i_eom   (i_in_item.end_of_message),
        .o_pos   (pos),
        .o_seq   (seq)
    );

    cbm_chain_ram #(
        .DEPTH (BLOCK_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (pos),
        .i_wr_en   (adv),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (new_fb),
        .o_rd_data (rd_data)
    );

    // Handshake: stage one moves on when the output register is free or drains.
    assign adv        = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Stage one: item captured together with the chain store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.data_byte <= i_in_item.data_byte;
            r_s1.eom       <= i_in_item.end_of_message;
            r_s1.err       <= i_in_item.end_of_message && !seq.block_end;
            r_s1.key_byte  <= seq.key_byte;
            r_s1.iv_byte   <= seq.iv_byte;
            r_s1.first     <= seq.first;
            r_s1_pos       <= pos;
        end
    end

    // Cipher and chaining: feedback comes from the IV in a message's first block.
    always_comb begin
        fb = r_s1.first ? r_s1.iv_byte : rd_data;
        if (cfg.chain_mode == MODE_CBC || cfg.chain_mode == MODE_PCBC) begin
            res = r_s1.data_byte ^ r_s1.key_byte ^ fb;
        end else begin
            res = r_s1.data_byte ^ r_s1.key_byte;
        end
        if (cfg.chain_mode == MODE_CBC) begin
            new_fb = cfg.decrypt_dir ? r_s1.data_byte : res;
        end else begin
            new_fb = r_s1.data_byte ^ res;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_byte     <= res;
            r_out.out_last     <= r_s1.eom;
            r_out.length_error <= r_s1.err;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef SYNTH
    // An item held in stage one is never dropped while the output is stalled.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !adv |=> r_s1_vld)
        else $error("stage one item lost");

    // The last item of a message restarts the sequencer from the IV.
    a_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.end_of_message |=> (pos == '0) && seq.first)
        else $error("sequencer did not restart after end of message");

    // A length error is only reported on the last item of a message.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.length_error |-> o_out_item.out_last)
        else $error("length error without end of message");

    // An item advanced out of stage one shows up in the output register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced item missing from output register");
`endif

endmodule

FILE: tb/tb_xor_block_cipher_modes.sv
`timescale 1ns / 100ps

module tb_xor_block_cipher_modes;
    import cbm_pkg::*;

    localparam int BLOCK_BYTES  = 16;
    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_ITEMS  = 150;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int LIMIT_CYCLES = 200000;

    // Codes the package does not name: the spare mode and an index past the list.
    localparam logic [1:0]  MODE_SPARE = 2'd3;
    localparam logic [2:0]  REG_UNUSED = 3'd7;
    localparam logic [63:0] ALL_ONES   = {64{1'b1}};
    localparam t_out_item   NO_RESULT  = '0;

    typedef enum logic [0:0] {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [2:0] idx;
        logic [63:0] value;
        logic [7:0] data;
        logic       eom;
        logic       typed;
        t_out_item  want;
    } t_row;

    // Directed stimulus. Typed expectations only where they are obvious.
    localparam int DIRECTED_COUNT = 30;
    localparam t_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Reset settings: ECB with a zero key passes bytes through.
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        // Message ending mid-block raises the length error.
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h3C, 1'b1, 1'b1, '{8'h3C, 1'b1, 1'b1}},
        '{ROW_REG, REG_KEY_LOW, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG, REG_KEY_HIGH, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h00, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        // Key length zero acts as one.
        '{ROW_REG, REG_KEY_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG, REG_KEY_LOW, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h12, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h34, 1'b0, 1'b0, NO_RESULT},
        // Key length above 16 acts as 16; upper data bits are dropped.
        '{ROW_REG, REG_KEY_LENGTH, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h56, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h65, 1'b0, 1'b0, NO_RESULT},
        // Shrinking the key mid-block wraps the running key index.
        '{ROW_REG, REG_KEY_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h78, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h9A, 1'b1, 1'b0, NO_RESULT},
        // CBC decrypt with an IV.
        '{ROW_REG, REG_CHAIN_MODE, 64'(MODE_CBC), 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG, REG_IV_LOW, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG, REG_IV_HIGH, 64'h8000_0000_0000_0001, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG, REG_DECRYPT_DIR, 64'd1, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h01, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h80, 1'b1, 1'b0, NO_RESULT},
        // PCBC encrypt.
        '{ROW_REG, REG_CHAIN_MODE, 64'(MODE_PCBC), 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG, REG_DECRYPT_DIR, 64'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'hFE, 1'b1, 1'b0, NO_RESULT},
        // The spare mode code behaves as ECB.
        '{ROW_REG, REG_CHAIN_MODE, 64'(MODE_SPARE), 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'hC3, 1'b1, 1'b0, NO_RESULT},
        // A write to an index past the register list changes nothing.
        '{ROW_REG, REG_UNUSED, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_UNUSED, 64'd0, 8'h00, 1'b1, 1'b0, NO_RESULT}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_idx     = '0;
    logic [63:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    t_in_item    in_item     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    t_out_item   out_item;

    // Typed expectation that travels with the item being offered.
    logic        drv_typed   = 1'b0;
    t_out_item   drv_want    = '0;

    // Shadow registers and cipher state of the predictor.
    logic [1:0]   sh_mode    = MODE_ECB;
    logic         sh_decrypt = 1'b0;
    logic [127:0] sh_key     = '0;
    logic [4:0]   sh_klen    = 5'd16;
    logic [127:0] sh_iv      = '0;
    logic [7:0]   chain_mem [BLOCK_BYTES];
    int           blk_pos    = 0;
    int           key_pos    = 0;
    logic         first_blk  = 1'b1;

    t_out_item expected_bytes [$];

    bit idle_en       = 1'b0;
    bit stall_en      = 1'b0;
    bit long_hold_req = 1'b0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int item_count    = 0;
    int msg_count     = 0;
    int len_err_count = 0;
    int chained_count = 0;
    int reg_writes    = 0;

    always #2 clk = ~clk;

    xor_block_cipher_modes #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Append one expectation at the tail of the queue.
    function automatic void queue_expected(input t_out_item entry);
        expected_bytes.insert(expected_bytes.size(), entry);
    endfunction

    // Predict one output byte and advance the position, key and chain state.
    task automatic cipher_step(input t_in_item it, output t_out_item res);
        int         pos;
        int         klen;
        int         kidx;
        logic [7:0] k;
        logic [7:0] f;
        logic [7:0] o;
        logic       blk_end;
        pos = blk_pos;
        if (sh_klen == 5'd0) begin
            klen = 1;
        end else if (sh_klen > 5'(MAX_KEY_BYTES)) begin
            klen = MAX_KEY_BYTES;
        end else begin
            klen = int'(sh_klen);
        end
        kidx = key_pos;
        if (kidx >= klen) begin
            kidx = 0;
        end
        k = sh_key[kidx * 8 +: 8];
        f = first_blk ? sh_iv[pos * 8 +: 8] : chain_mem[pos];
        if (sh_mode == MODE_CBC || sh_mode == MODE_PCBC) begin
            o = it.data_byte ^ k ^ f;
            if (!first_blk) begin
                chained_count++;
            end
        end else begin
            o = it.data_byte ^ k;
        end
        // Feedback is stored in every mode, so the chain is always defined.
        if (sh_mode == MODE_CBC) begin
            chain_mem[pos] = sh_decrypt ? it.data_byte : o;
        end else begin
            chain_mem[pos] = it.data_byte ^ o;
        end
        blk_end = (pos == BLOCK_BYTES - 1);
        res.out_byte     = o;
        res.out_last     = it.end_of_message;
        res.length_error = it.end_of_message && !blk_end;
        if (it.end_of_message) begin
            blk_pos   = 0;
            key_pos   = 0;
            first_blk = 1'b1;
            msg_count++;
            if (!blk_end) begin
                len_err_count++;
            end
        end else if (blk_end) begin
            blk_pos   = 0;
            key_pos   = 0;
            first_blk = 1'b0;
        end else begin
            blk_pos = pos + 1;
            key_pos = (kidx + 1 >= klen) ? 0 : kidx + 1;
        end
        item_count++;
    endtask

    // Check each delivered item against the oldest expectation, then predict new items.
    always @(posedge clk) begin : monitor
        t_out_item want;
        t_out_item pred;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("result item with no expectation waiting: %03h", out_item);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_item.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, out_item.out_byte);
                        fail_count++;
                    end
                    if (out_item.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               want.out_last, out_item.out_last);
                        fail_count++;
                    end
                    if (out_item.length_error !== want.length_error) begin
                        $error("length_error: expected %0b, got %0b",
                               want.length_error, out_item.length_error);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                cipher_step(in_item, pred);
                queue_expected(drv_typed ? drv_want : pred);
            end
        end
    end

    // Output side: ready by default, short random stalls, one long hold on request.
    initial begin
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
        end
        return gap;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        case ($urandom_range(0, 5))
            0: begin
                w = '0;
            end
            1: begin
                w = ALL_ONES;
            end
            default: begin
                w = {$urandom, $urandom};
            end
        endcase
        return w;
    endfunction

    // Offer one item after an optional gap and hold it until it is taken.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want,
                             input int gap);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_item   <= it;
        drv_typed <= typed;
        drv_want  <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering, wait for every result, then let the pipeline settle.
    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register on the port and in the predictor's shadow copy.
    task automatic apply_register(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            REG_CHAIN_MODE: begin
                sh_mode = value[1:0];
            end
            REG_DECRYPT_DIR: begin
                sh_decrypt = value[0];
            end
            REG_KEY_LOW: begin
                sh_key[63:0] = value;
            end
            REG_KEY_HIGH: begin
                sh_key[127:64] = value;
            end
            REG_KEY_LENGTH: begin
                sh_klen = value[4:0];
            end
            REG_IV_LOW: begin
                sh_iv[63:0] = value;
            end
            REG_IV_HIGH: begin
                sh_iv[127:64] = value;
            end
            default: begin
            end
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // New settings for a phase, leaning on the extremes.
    task automatic randomize_registers();
        logic [63:0] v;
        if ($urandom_range(0, 1) == 1) begin
            v = rand_word();
            v[1:0] = 2'($urandom_range(0, 3));
            apply_register(REG_CHAIN_MODE, v);
        end
        if ($urandom_range(0, 1) == 1) begin
            apply_register(REG_DECRYPT_DIR, rand_word());
        end
        if ($urandom_range(0, 1) == 1) begin
            apply_register(REG_KEY_LOW, rand_word());
        end
        if ($urandom_range(0, 1) == 1) begin
            apply_register(REG_KEY_HIGH, rand_word());
        end
        if ($urandom_range(0, 1) == 1) begin
            v = rand_word();
            case ($urandom_range(0, 5))
                0: begin
                    v[4:0] = 5'd0;
                end
                1: begin
                    v[4:0] = 5'd1;
                end
                2: begin
                    v[4:0] = 5'd16;
                end
                3: begin
                    v[4:0] = 5'd31;
                end
                default: begin
                    v[4:0] = 5'($urandom_range(1, 16));
                end
            endcase
            apply_register(REG_KEY_LENGTH, v);
        end
        if ($urandom_range(0, 1) == 1) begin
            apply_register(REG_IV_LOW, rand_word());
        end
        if ($urandom_range(0, 1) == 1) begin
            apply_register(REG_IV_HIGH, rand_word());
        end
        if ($urandom_range(0, 9) == 0) begin
            apply_register(REG_UNUSED, rand_word());
        end
    endtask

    // Mostly whole-block messages; some end mid-block and some never end.
    task automatic send_message(output int count);
        int       len;
        int       shape;
        t_in_item it;
        shape = $urandom_range(0, 9);
        if (shape < 7) begin
            len = BLOCK_BYTES * $urandom_range(1, 3);
        end else begin
            len = $urandom_range(1, 40);
        end
        for (int i = 0; i < len; i++) begin
            it.data_byte      = 8'($urandom_range(0, 255));
            it.end_of_message = (shape != 9) && (i == len - 1);
            send_item(it, 1'b0, NO_RESULT, pick_gap());
        end
        count = len;
    endtask

    // Main sequence: reset, directed table, then random phases.
    initial begin : stimulus
        t_in_item it;
        int       rand_sent;
        int       phase;
        int       phase_target;
        int       phase_sent;
        int       n;
        rand_sent = 0;
        phase     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_en  = 1'b1;
        stall_en = 1'b1;
        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_REG) begin
                wait_results_done();
                apply_register(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
            end else begin
                it.data_byte      = DIRECTED_ROWS[r].data;
                it.end_of_message = DIRECTED_ROWS[r].eom;
                send_item(it, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want, pick_gap());
            end
        end

        while (rand_sent < RANDOM_ITEMS) begin
            // Phase boundary: the sender pauses until every result is back.
            wait_results_done();
            randomize_registers();
            if (rand_sent > RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_en  = 1'b0;
                stall_en = 1'b0;
            end else if (phase == 2) begin
                // Keep offering items while the receiver holds off, so the block backs up.
                idle_en       = 1'b0;
                stall_en      = 1'b0;
                long_hold_req = 1'b1;
            end else begin
                idle_en  = ($urandom_range(0, 3) != 0);
                stall_en = ($urandom_range(0, 3) != 0);
            end
            phase_target = $urandom_range(40, 120);
            phase_sent   = 0;
            while (phase_sent < phase_target && rand_sent < RANDOM_ITEMS) begin
                send_message(n);
                phase_sent += n;
                rand_sent  += n;
            end
            phase++;
        end

        wait_results_done();
        repeat (8) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            $error("%0d expected result items never arrived", expected_bytes.size());
            fail_count++;
        end
        $display("Covered %0d items in %0d messages, %0d of them ended mid-block.",
                 item_count, msg_count, len_err_count);
        $display("Chained %0d bytes; %0d register writes over %0d random phases.",
                 chained_count, reg_writes, phase);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
